[hw/rtl/bilinear_image_upscaler_defines.svh]
// Assertion helpers for the bilinear upscaler.
// Each macro assumes a clock named clk and an active-low reset named arst_n.
`ifndef BILINEAR_IMAGE_UPSCALER_DEFINES_SVH
`define BILINEAR_IMAGE_UPSCALER_DEFINES_SVH

// Same-cycle implication.
`define BIU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication.
`define BIU_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

[hw/rtl/biu_pkg.sv]
package biu_pkg;

	// Fixed field widths.
	localparam int PIX_W      = 8;
	localparam int SRC_W      = 8;
	localparam int COORD_W    = 11;
	localparam int ZOOM_W     = 4;
	localparam int DIM_REG_W  = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ZOOM   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

	// Operation codes.
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

endpackage

[hw/rtl/biu_div.sv]
module biu_div #(
	parameter int NW = 36,
	parameter int DW = 26
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW:0]     rem_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   den_q;
	logic [DW:0]     trial;
	logic [DW:0]     diff;
	logic            ge;

	// Shift in the next numerator bit and try a subtract.
	always_comb begin
		trial = {rem_q[DW-1:0], quo_q[NW-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	// Restoring divide, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff : trial;
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q[DW-1:0];

endmodule

[hw/rtl/bilinear_image_upscaler.sv]
// Bilinear upscaler: a load word (op 0) writes one RGB source pixel into the
// on-chip pixel store and gives no result. A compute word (op 1) returns one
// pixel of the image enlarged by zoom_factor, blended exactly in integers
// from four store reads and truncated. A coordinate outside the enlarged
// image returns coord_error with zero channels. In an in-range compute the
// bit-serial divider is shared by the two coordinate divides and the three
// channel divides, and dominates the time taken; one shared multiplier forms
// all products and the single-port store is read four times. A stalled
// earlier result adds its stall time. The block takes no new word while a
// compute is in flight. The store holds no reset value; a compute must only
// touch loaded pixels.
`include "bilinear_image_upscaler_defines.svh"

module bilinear_image_upscaler #(
	parameter int MAX_SRC_DIM = 256,
	parameter int MAX_ZOOM    = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [biu_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [biu_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            op,
	input  logic [biu_pkg::SRC_W-1:0]       src_col,
	input  logic [biu_pkg::SRC_W-1:0]       src_row,
	input  logic [biu_pkg::PIX_W-1:0]       in_red,
	input  logic [biu_pkg::PIX_W-1:0]       in_green,
	input  logic [biu_pkg::PIX_W-1:0]       in_blue,
	input  logic [biu_pkg::COORD_W-1:0]     out_col,
	input  logic [biu_pkg::COORD_W-1:0]     out_row,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [biu_pkg::PIX_W-1:0]       out_red,
	output logic [biu_pkg::PIX_W-1:0]       out_green,
	output logic [biu_pkg::PIX_W-1:0]       out_blue,
	output logic                            coord_error
);
	import biu_pkg::*;

	localparam int DIMW  = $clog2(MAX_SRC_DIM + 1);
	localparam int ZW    = $clog2(MAX_ZOOM + 1);
	localparam int DXW   = DIMW + ZW;
	localparam int DENW  = 2 * DXW;
	localparam int MBW   = (DXW > COORD_W) ? DXW : COORD_W;
	localparam int PRW   = DENW + MBW;
	localparam int SW    = DENW + PIX_W + 2;
	localparam int DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_DX, S_DY, S_CHK, S_PX, S_DIVX, S_PY, S_DIVY,
		S_WGT, S_RD, S_MAC, S_DIVS, S_DIVC, S_FIN
	} state_t;

	state_t state_q;

	logic [ZOOM_W-1:0]    zoom_q;
	logic [DIM_REG_W-1:0] width_q;
	logic [DIM_REG_W-1:0] height_q;
	logic [ZW-1:0]        z_c;
	logic [DIMW-1:0]      w_c;
	logic [DIMW-1:0]      h_c;

	logic [COORD_W-1:0]   col_q;
	logic [COORD_W-1:0]   row_q;
	logic [DXW-1:0]       dx_q;
	logic [DXW-1:0]       dy_q;
	logic [DENW-1:0]      den_q;
	logic [DIMW-1:0]      x_q;
	logic [DIMW-1:0]      y_q;
	logic [DXW-1:0]       fx_q;
	logic [DXW-1:0]       fy_q;
	logic [DENW-1:0]      wt_q [4];
	logic [23:0]          pix_q [4];
	logic [SW-1:0]        acc_q;
	logic [1:0]           t_q;
	logic [1:0]           ch_q;
	logic [2:0]           rd_cnt_q;
	logic [PIX_W-1:0]     res_q [3];
	logic                 err_q;

	logic                 out_valid_q;
	logic [PIX_W-1:0]     ored_q;
	logic [PIX_W-1:0]     ogreen_q;
	logic [PIX_W-1:0]     oblue_q;
	logic                 oerr_q;

	logic [DENW-1:0]      mul_a;
	logic [MBW-1:0]       mul_b;
	logic [PRW-1:0]       prod;
	logic [PIX_W-1:0]     chan;

	logic                 div_start;
	logic [SW-1:0]        div_num;
	logic [DENW-1:0]      div_den;
	logic                 div_done;
	logic [SW-1:0]        div_quo;
	logic [DENW-1:0]      div_rem;

	logic [23:0]          mem [DEPTH];
	logic [23:0]          rdata_q;
	logic [AW-1:0]        mem_addr;
	logic                 mem_we;
	logic [DIMW-1:0]      rd_col;
	logic [DIMW-1:0]      rd_row;
	logic                 accept;

	// Clamp configuration into range.
	always_comb begin
		if (zoom_q < ZOOM_W'(1))             z_c = ZW'(1);
		else if (32'(zoom_q) > MAX_ZOOM)     z_c = ZW'(MAX_ZOOM);
		else                                 z_c = ZW'(zoom_q);
		if (width_q < DIM_REG_W'(2))         w_c = DIMW'(2);
		else if (32'(width_q) > MAX_SRC_DIM) w_c = DIMW'(MAX_SRC_DIM);
		else                                 w_c = DIMW'(width_q);
		if (height_q < DIM_REG_W'(2))         h_c = DIMW'(2);
		else if (32'(height_q) > MAX_SRC_DIM) h_c = DIMW'(MAX_SRC_DIM);
		else                                  h_c = DIMW'(height_q);
	end

	// Write configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q   <= ZOOM_W'(1);
			width_q  <= DIM_REG_W'(256);
			height_q <= DIM_REG_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ZOOM:   zoom_q   <= cfg_data[ZOOM_W-1:0];
				CFG_WIDTH:  width_q  <= cfg_data[DIM_REG_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[DIM_REG_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// Pick the channel of the current neighbor.
	always_comb begin
		case (ch_q)
			2'd0:    chan = pix_q[t_q][23:16];
			2'd1:    chan = pix_q[t_q][15:8];
			default: chan = pix_q[t_q][7:0];
		endcase
	end

	// Route operands into the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_DX: begin
				mul_a = DENW'(w_c);
				mul_b = MBW'(z_c);
			end
			S_DY: begin
				mul_a = DENW'(h_c);
				mul_b = MBW'(z_c);
			end
			S_CHK: begin
				mul_a = DENW'(dx_q);
				mul_b = MBW'(dy_q);
			end
			S_PX: begin
				mul_a = DENW'(w_c - 1'b1);
				mul_b = MBW'(col_q);
			end
			S_PY: begin
				mul_a = DENW'(h_c - 1'b1);
				mul_b = MBW'(row_q);
			end
			S_WGT: begin
				mul_a = t_q[0] ? DENW'(fx_q) : DENW'(dx_q - fx_q);
				mul_b = t_q[1] ? MBW'(fy_q) : MBW'(dy_q - fy_q);
			end
			S_MAC: begin
				mul_a = wt_q[t_q];
				mul_b = MBW'(chan);
			end
			default: ;
		endcase
		prod = PRW'(mul_a) * PRW'(mul_b);
	end

	// Feed the shared divider.
	always_comb begin
		div_start = (state_q == S_PX) || (state_q == S_PY) || (state_q == S_DIVS);
		case (state_q)
			S_PX: begin
				div_num = SW'(prod);
				div_den = DENW'(dx_q);
			end
			S_PY: begin
				div_num = SW'(prod);
				div_den = DENW'(dy_q);
			end
			default: begin
				div_num = acc_q;
				div_den = den_q;
			end
		endcase
	end

	biu_div #(
		.NW (SW),
		.DW (DENW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// Address the store: load writes when idle, neighbor reads otherwise.
	always_comb begin
		rd_col = x_q + DIMW'(rd_cnt_q[0]);
		rd_row = y_q + DIMW'(rd_cnt_q[1]);
		mem_we = accept && (op == OP_LOAD) &&
		         (32'(src_col) < MAX_SRC_DIM) && (32'(src_row) < MAX_SRC_DIM);
		if (state_q == S_IDLE)
			mem_addr = AW'(AW'(src_row) * AW'(MAX_SRC_DIM) + AW'(src_col));
		else
			mem_addr = AW'(AW'(rd_row) * AW'(MAX_SRC_DIM) + AW'(rd_col));
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= {in_red, in_green, in_blue};
		rdata_q <= mem[mem_addr];
	end

	// Sequence one compute word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			t_q         <= '0;
			ch_q        <= '0;
			rd_cnt_q    <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FIN)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && op == OP_COMPUTE) begin
						col_q   <= out_col;
						row_q   <= out_row;
						state_q <= S_DX;
					end
				end
				S_DX: begin
					dx_q    <= DXW'(prod);
					state_q <= S_DY;
				end
				S_DY: begin
					dy_q    <= DXW'(prod);
					state_q <= S_CHK;
				end
				S_CHK: begin
					den_q <= DENW'(prod);
					if (32'(col_q) >= 32'(dx_q) || 32'(row_q) >= 32'(dy_q)) begin
						err_q    <= 1'b1;
						res_q[0] <= '0;
						res_q[1] <= '0;
						res_q[2] <= '0;
						state_q  <= S_FIN;
					end else begin
						err_q   <= 1'b0;
						state_q <= S_PX;
					end
				end
				S_PX: state_q <= S_DIVX;
				S_DIVX: begin
					if (div_done) begin
						x_q     <= DIMW'(div_quo);
						fx_q    <= DXW'(div_rem);
						state_q <= S_PY;
					end
				end
				S_PY: state_q <= S_DIVY;
				S_DIVY: begin
					if (div_done) begin
						y_q     <= DIMW'(div_quo);
						fy_q    <= DXW'(div_rem);
						t_q     <= '0;
						state_q <= S_WGT;
					end
				end
				S_WGT: begin
					wt_q[t_q] <= DENW'(prod);
					t_q       <= t_q + 1'b1;
					if (t_q == 2'd3) begin
						rd_cnt_q <= '0;
						state_q  <= S_RD;
					end
				end
				S_RD: begin
					if (rd_cnt_q != 3'd0)
						pix_q[2'(rd_cnt_q - 3'd1)] <= rdata_q;
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == 3'd4) begin
						acc_q   <= '0;
						t_q     <= '0;
						ch_q    <= '0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					acc_q <= acc_q + SW'(prod);
					t_q   <= t_q + 1'b1;
					if (t_q == 2'd3)
						state_q <= S_DIVS;
				end
				S_DIVS: state_q <= S_DIVC;
				S_DIVC: begin
					if (div_done) begin
						res_q[ch_q] <= div_quo[PIX_W-1:0];
						acc_q       <= '0;
						if (ch_q == 2'd2) begin
							state_q <= S_FIN;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_MAC;
						end
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						ored_q      <= res_q[0];
						ogreen_q    <= res_q[1];
						oblue_q     <= res_q[2];
						oerr_q      <= err_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_red     = ored_q;
	assign out_green   = ogreen_q;
	assign out_blue    = oblue_q;
	assign coord_error = oerr_q;

	`BIU_ASSERT_IMP(a_err_zero, out_valid && coord_error, out_red == '0 && out_green == '0 && out_blue == '0)
	`BIU_ASSERT_IMP(a_div_wait, div_done, state_q == S_DIVX || state_q == S_DIVY || state_q == S_DIVC)
	`BIU_ASSERT_NXT(a_cmp_start, in_valid && !in_stall && op == OP_COMPUTE, state_q == S_DX)

endmodule
